[rtl/izn_pkg.sv]
// Shared types, constants and fixed-point helpers of the neuron update block.
`default_nettype none
package izn_pkg;

    localparam int NEURONS_DEF = 1024;
    localparam logic [15:0] ADAPT_COUPLING = 16'd13107;
    localparam logic signed [31:0] CONST_0140 = 32'sd2348810;

    localparam logic [30:0] STEP_SCALE_INIT      = 31'd1677722;
    localparam logic [30:0] ADAPT_RATE_INIT      = 31'd33554;
    localparam logic signed [31:0] RESET_VOLTAGE_INIT = -32'sd1090519;
    localparam logic signed [31:0] ADAPT_INC_INIT     = 32'sd33554;
    localparam logic signed [31:0] THRESHOLD_INIT     = 32'sd503316;
    localparam logic signed [31:0] GABA_REV_INIT      = -32'sd1342177;
    localparam logic [15:0] DECAY_AMPA_INIT      = 16'd64238;
    localparam logic [15:0] DECAY_GABA_INIT      = 16'd64884;

    localparam logic [3:0] CALC_LAST = 4'd9;

    typedef enum logic [1:0] {
        REQ_STEP = 2'd0,
        REQ_BG   = 2'd1,
        REQ_AMPA = 2'd2,
        REQ_GABA = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        CFG_STEP_SCALE = 3'd0,
        CFG_ADAPT_RATE = 3'd1,
        CFG_RESET_V    = 3'd2,
        CFG_ADAPT_INC  = 3'd3,
        CFG_THRESHOLD  = 3'd4,
        CFG_GABA_REV   = 3'd5,
        CFG_DECAY_AMPA = 3'd6,
        CFG_DECAY_GABA = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic signed [31:0] bg;
        logic signed [31:0] gg;
        logic signed [31:0] ga;
        logic signed [31:0] u;
        logic signed [31:0] v;
    } nrn_state_t;

    // Saturate a wide signed value to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
        logic ovf;
        ovf = (x[51:31] != {21{1'b0}}) && (x[51:31] != {21{1'b1}});
        if (!ovf)
            return x[31:0];
        else if (x[51])
            return {1'b1, {31{1'b0}}};
        else
            return {1'b0, {31{1'b1}}};
    endfunction

    // Round by 2^24, ties toward plus infinity.
    function automatic logic signed [51:0] rnd24(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + 66'sd8388608;
        return {{10{t[65]}}, t[65:24]};
    endfunction

    // Round by 2^16, ties toward plus infinity.
    function automatic logic signed [51:0] rnd16(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + 66'sd32768;
        return {{2{t[65]}}, t[65:16]};
    endfunction

endpackage
`default_nettype wire

[rtl/izhikevich_neuron_update.sv]
// Izhikevich neuron state table with one shared multiplier and a step sequencer.
// A step request runs through the read, calculation and write-back states; a write or
// conductance request, or an out-of-range step, skips the calculation state, and a
// stalled output holds the write-back state. One request is taken at a time, in idle;
// the single 33x33 multiplier, used once per calculation cycle, sets the step pace.
// Reset: asynchronous, active low; then a clearing pass loads every state entry with
// its reset value while no request is taken (config writes still are).
`default_nettype none
module izhikevich_neuron_update #(
    parameter int NEURONS = izn_pkg::NEURONS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [9:0] neuron_index, [41:10] value, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [9:0] neuron_id, [41:10] membrane_out, rest zero
    output logic [0:0]       m_tuser,   // [0] spiked
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

    // configuration registers
    logic [30:0]        step_scale_reg;
    logic [30:0]        adapt_rate_reg;
    logic signed [31:0] reset_v_reg;
    logic signed [31:0] adapt_inc_reg;
    logic signed [31:0] threshold_reg;
    logic signed [31:0] gaba_rev_reg;
    logic [15:0]        decay_ampa_reg;
    logic [15:0]        decay_gaba_reg;

    izn_pkg::state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [3:0]    calc_cnt_reg;

    // captured request
    izn_pkg::req_type_t req_type_reg;
    logic [9:0]         idx_reg;
    logic signed [31:0] value_reg;
    logic               in_range_reg;
    logic [AW-1:0]      addr_reg;

    // state table
    izn_pkg::nrn_state_t mem [NEURONS];
    izn_pkg::nrn_state_t rd_reg;
    izn_pkg::nrn_state_t mem_wdata;
    logic [AW-1:0]       mem_waddr;
    logic                mem_we;

    // shared multiplier and datapath registers
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;
    logic signed [51:0] acc_reg;
    logic signed [31:0] diff_reg, dv_reg, v1_reg, w_reg, u1_reg, ga_new_reg, gg_new_reg;

    // output register
    logic               out_valid_reg;
    logic [9:0]         out_id_reg;
    logic               out_spk_reg;
    logic signed [31:0] out_mem_reg;

    logic               out_free;
    logic               accept;
    logic               spike;
    logic signed [31:0] v_fin, u_fin, res_mem;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    // configuration port: index covers all eight registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_scale_reg <= izn_pkg::STEP_SCALE_INIT;
            adapt_rate_reg <= izn_pkg::ADAPT_RATE_INIT;
            reset_v_reg    <= izn_pkg::RESET_VOLTAGE_INIT;
            adapt_inc_reg  <= izn_pkg::ADAPT_INC_INIT;
            threshold_reg  <= izn_pkg::THRESHOLD_INIT;
            gaba_rev_reg   <= izn_pkg::GABA_REV_INIT;
            decay_ampa_reg <= izn_pkg::DECAY_AMPA_INIT;
            decay_gaba_reg <= izn_pkg::DECAY_GABA_INIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (izn_pkg::cfg_reg_t'(cfg_index))
                izn_pkg::CFG_STEP_SCALE: step_scale_reg <= cfg_data[30:0];
                izn_pkg::CFG_ADAPT_RATE: adapt_rate_reg <= cfg_data[30:0];
                izn_pkg::CFG_RESET_V:    reset_v_reg    <= cfg_data;
                izn_pkg::CFG_ADAPT_INC:  adapt_inc_reg  <= cfg_data;
                izn_pkg::CFG_THRESHOLD:  threshold_reg  <= cfg_data;
                izn_pkg::CFG_GABA_REV:   gaba_rev_reg   <= cfg_data;
                izn_pkg::CFG_DECAY_AMPA: decay_ampa_reg <= cfg_data[15:0];
                izn_pkg::CFG_DECAY_GABA: decay_gaba_reg <= cfg_data[15:0];
            endcase
        end
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            izn_pkg::ST_CLEAR:
                if (clr_cnt_reg == AW'(NEURONS - 1))
                    state_next = izn_pkg::ST_IDLE;
            izn_pkg::ST_IDLE:
                if (accept)
                    state_next = izn_pkg::ST_READ;
            izn_pkg::ST_READ:
                // only an in-range step needs the multiplier sequence
                if (req_type_reg == izn_pkg::REQ_STEP && in_range_reg)
                    state_next = izn_pkg::ST_CALC;
                else
                    state_next = izn_pkg::ST_WRITE;
            izn_pkg::ST_CALC:
                if (calc_cnt_reg == izn_pkg::CALC_LAST)
                    state_next = izn_pkg::ST_WRITE;
            izn_pkg::ST_WRITE:
                if (out_free)
                    state_next = izn_pkg::ST_IDLE;
            default:
                state_next = izn_pkg::ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        s_tready  = (state_reg == izn_pkg::ST_IDLE);
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        if (state_reg == izn_pkg::ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
        end
        else if (state_reg == izn_pkg::ST_WRITE)
            mem_we = out_free && in_range_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= izn_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            calc_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == izn_pkg::ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (state_reg == izn_pkg::ST_CALC)
                calc_cnt_reg <= calc_cnt_reg + 4'd1;
            else
                calc_cnt_reg <= '0;
        end
    end

    // capture the request transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= izn_pkg::req_type_t'(s_tuser);
            idx_reg      <= s_tdata[9:0];
            value_reg    <= s_tdata[41:10];
            in_range_reg <= ({22'd0, s_tdata[9:0]} < 32'(NEURONS));
            addr_reg     <= AW'({{AW{1'b0}}, s_tdata[9:0]});
        end
    end

    // state table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_reg <= mem[addr_reg];
    end

    // multiplier operand select per sequencer cycle
    always_comb
    begin
        mul_a = {rd_reg.v[31], rd_reg.v};
        mul_b = {rd_reg.v[31], rd_reg.v};
        unique case (calc_cnt_reg)
            4'd0:
            begin
                mul_a = {rd_reg.v[31], rd_reg.v};
                mul_b = {rd_reg.v[31], rd_reg.v};
            end
            4'd1:
            begin
                mul_a = {rd_reg.ga[31], rd_reg.ga};
                mul_b = {rd_reg.v[31], rd_reg.v};
            end
            4'd2:
            begin
                mul_a = {rd_reg.gg[31], rd_reg.gg};
                mul_b = {diff_reg[31], diff_reg};
            end
            4'd3:
            begin
                mul_a = {rd_reg.ga[31], rd_reg.ga};
                mul_b = {17'd0, decay_ampa_reg};
            end
            4'd4:
            begin
                mul_a = {2'b00, step_scale_reg};
                mul_b = {dv_reg[31], dv_reg};
            end
            4'd5:
            begin
                mul_a = {rd_reg.gg[31], rd_reg.gg};
                mul_b = {17'd0, decay_gaba_reg};
            end
            4'd6:
            begin
                mul_a = {17'd0, izn_pkg::ADAPT_COUPLING};
                mul_b = {v1_reg[31], v1_reg};
            end
            4'd8:
            begin
                mul_a = {2'b00, adapt_rate_reg};
                mul_b = {w_reg[31], w_reg};
            end
            default:
            begin
                mul_a = {rd_reg.v[31], rd_reg.v};
                mul_b = {rd_reg.v[31], rd_reg.v};
            end
        endcase
    end

    // datapath: each calculation cycle issues one product, and most fold in the previous one
    always_ff @(posedge clk)
    begin
        if (state_reg == izn_pkg::ST_CALC)
        begin
            prod_reg <= mul_a * mul_b;
            unique case (calc_cnt_reg)
                4'd0: diff_reg <= izn_pkg::sat32(52'(rd_reg.v) - 52'(gaba_rev_reg));
                4'd1: acc_reg  <= (izn_pkg::rnd24(prod_reg) <<< 5)
                                + (izn_pkg::rnd24(prod_reg) <<< 3)
                                + (52'(rd_reg.v) <<< 2) + 52'(rd_reg.v)
                                + 52'(izn_pkg::CONST_0140) - 52'(rd_reg.u)
                                + 52'(rd_reg.bg);
                4'd2: acc_reg  <= acc_reg - izn_pkg::rnd24(prod_reg);
                4'd3: dv_reg   <= izn_pkg::sat32(acc_reg - izn_pkg::rnd24(prod_reg));
                4'd4: ga_new_reg <= izn_pkg::sat32(izn_pkg::rnd16(prod_reg));
                4'd5: v1_reg   <= izn_pkg::sat32(52'(rd_reg.v) + izn_pkg::rnd24(prod_reg));
                4'd6: gg_new_reg <= izn_pkg::sat32(izn_pkg::rnd16(prod_reg));
                4'd7: w_reg    <= izn_pkg::sat32(izn_pkg::rnd16(prod_reg) - 52'(rd_reg.u));
                4'd9: u1_reg   <= izn_pkg::sat32(52'(rd_reg.u) + izn_pkg::rnd24(prod_reg));
                default: ;
            endcase
        end
    end

    // spike check and write-back word
    always_comb
    begin
        spike = (v1_reg > threshold_reg);
        v_fin = spike ? reset_v_reg : v1_reg;
        u_fin = spike ? izn_pkg::sat32(52'(u1_reg) + 52'(adapt_inc_reg)) : u1_reg;

        mem_wdata = rd_reg;
        if (state_reg == izn_pkg::ST_CLEAR)
        begin
            mem_wdata   = '0;
            mem_wdata.v = izn_pkg::RESET_VOLTAGE_INIT;
        end
        else
        begin
            unique case (req_type_reg)
                izn_pkg::REQ_STEP:
                begin
                    mem_wdata.v  = v_fin;
                    mem_wdata.u  = u_fin;
                    mem_wdata.ga = ga_new_reg;
                    mem_wdata.gg = gg_new_reg;
                end
                izn_pkg::REQ_BG:
                    mem_wdata.bg = value_reg;
                izn_pkg::REQ_AMPA:
                    mem_wdata.ga = izn_pkg::sat32(52'(rd_reg.ga) + 52'(value_reg));
                izn_pkg::REQ_GABA:
                    mem_wdata.gg = izn_pkg::sat32(52'(rd_reg.gg) + 52'(value_reg));
            endcase
        end

        if (!in_range_reg)
            res_mem = '0;
        else if (req_type_reg == izn_pkg::REQ_STEP)
            res_mem = v_fin;
        else
            res_mem = rd_reg.v;
    end

    // output register: hold the result until the master side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == izn_pkg::ST_WRITE && out_free)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == izn_pkg::ST_WRITE && out_free)
        begin
            out_id_reg  <= idx_reg;
            out_spk_reg <= in_range_reg && (req_type_reg == izn_pkg::REQ_STEP) && spike;
            out_mem_reg <= res_mem;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {6'd0, out_mem_reg, out_id_reg};
    assign m_tuser[0] = out_spk_reg;

    // a new result only comes out of the write-back state
    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == izn_pkg::ST_WRITE)
        else $error("result raised outside write-back");

    // the step sequence never runs past its last cycle
    a_calc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == izn_pkg::ST_CALC |-> calc_cnt_reg <= izn_pkg::CALC_LAST)
        else $error("step counter overran");

    // no request is taken during the clearing pass
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == izn_pkg::ST_CLEAR |-> !s_tready)
        else $error("request ready during clearing pass");

    // a spiking result carries the reset voltage
    a_spike_reset_v: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tdata[41:10] == reset_v_reg)
        else $error("spike without reset voltage");

    // write-back with a free output returns to idle
    a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == izn_pkg::ST_WRITE && out_free) |=> state_reg == izn_pkg::ST_IDLE)
        else $error("write-back did not complete");

endmodule
`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench of the neuron state table update block over its request stream.
`timescale 1ns / 100ps

module testbench;

    localparam int NRN           = 1024;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 265;
    localparam int MAX_GAP       = 17;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 30;
    localparam int CYCLE_LIMIT   = 900000;
    localparam logic signed [31:0] V_RST = izn_pkg::RESET_VOLTAGE_INIT;

    // Result fields as they leave the block.
    typedef struct {
        logic [9:0]  id;
        logic        spk;
        logic signed [31:0] mem;
    } nrn_result_t;

    // One row of the directed stimulus; typed rows carry their own result.
    typedef struct {
        izn_pkg::req_type_t rtype;
        logic [9:0]  idx;
        logic [31:0] value;
        bit          typed;
        logic        spk;
        logic signed [31:0] mem;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // [9:0] neuron_index, [41:10] value, rest zero
    logic [1:0]  s_tuser;   // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // [9:0] neuron_id, [41:10] membrane_out, rest zero
    logic [0:0]  m_tuser;   // [0] spiked
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    izhikevich_neuron_update u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Mirror of the block's registers and state table.
    logic [30:0]        mdl_step_scale;
    logic [30:0]        mdl_adapt_rate;
    logic signed [31:0] mdl_reset_v;
    logic signed [31:0] mdl_adapt_inc;
    logic signed [31:0] mdl_threshold;
    logic signed [31:0] mdl_gaba_rev;
    logic [15:0]        mdl_decay_ampa;
    logic [15:0]        mdl_decay_gaba;

    int mem_v  [NRN];
    int mem_u  [NRN];
    int mem_ga [NRN];
    int mem_gg [NRN];
    int mem_bg [NRN];

    nrn_result_t pending_results[$];   // oldest expected result first
    nrn_result_t typed_results[$];     // typed-in results of directed rows, in order
    bit          typed_flags[$];       // per accepted request: take typed result or not
    stim_row_t   dir_rows[20];

    int  fail_count;
    int  cycle_count;
    bit  hold_request;   // ask the receiver for one long hold-off
    bit  burst_mode;     // no idling on either side while set

    // Clock and timeout.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Saturate to signed 32 bits.
    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // Scale back by 2^n, rounding to nearest with ties toward plus infinity.
    function automatic longint round_shift(input longint x, input int n);
        return (x + (64'sd1 << (n - 1))) >>> n;
    endfunction

    function automatic void reset_table();
        for (int i = 0; i < NRN; i++)
        begin
            mem_v[i]  = izn_pkg::RESET_VOLTAGE_INIT;
            mem_u[i]  = 0;
            mem_ga[i] = 0;
            mem_gg[i] = 0;
            mem_bg[i] = 0;
        end
    endfunction

    function automatic void apply_config(input logic [2:0] idx, input logic [31:0] data);
        case (izn_pkg::cfg_reg_t'(idx))
            izn_pkg::CFG_STEP_SCALE: mdl_step_scale = data[30:0];
            izn_pkg::CFG_ADAPT_RATE: mdl_adapt_rate = data[30:0];
            izn_pkg::CFG_RESET_V:    mdl_reset_v    = data;
            izn_pkg::CFG_ADAPT_INC:  mdl_adapt_inc  = data;
            izn_pkg::CFG_THRESHOLD:  mdl_threshold  = data;
            izn_pkg::CFG_GABA_REV:   mdl_gaba_rev   = data;
            izn_pkg::CFG_DECAY_AMPA: mdl_decay_ampa = data[15:0];
            izn_pkg::CFG_DECAY_GABA: mdl_decay_gaba = data[15:0];
            default: ;
        endcase
    endfunction

    // Advance the mirrored table by one request and return the result it causes.
    function automatic nrn_result_t update_neuron(input izn_pkg::req_type_t rtype,
                                                  input logic [9:0] idx,
                                                  input logic signed [31:0] value);
        nrn_result_t res;
        longint v, u, ga, gg, diff, sum, w;
        longint dv, v1, u1;
        res.id  = idx;
        res.spk = 1'b0;
        v  = mem_v[idx];
        u  = mem_u[idx];
        ga = mem_ga[idx];
        gg = mem_gg[idx];
        case (rtype)
            izn_pkg::REQ_STEP:
            begin
                diff = clamp32(v - longint'(mdl_gaba_rev));
                sum = 40 * round_shift(v * v, 24) + 5 * v + longint'(izn_pkg::CONST_0140) - u
                    + longint'(mem_bg[idx]) - round_shift(ga * v, 24)
                    - round_shift(gg * diff, 24);
                dv = clamp32(sum);
                v1 = clamp32(v + round_shift(longint'(mdl_step_scale) * dv, 24));
                w  = clamp32(round_shift(longint'(izn_pkg::ADAPT_COUPLING) * v1, 16) - u);
                u1 = clamp32(u + round_shift(longint'(mdl_adapt_rate) * w, 24));
                if (v1 > longint'(mdl_threshold))
                begin
                    res.spk = 1'b1;
                    v1 = mdl_reset_v;
                    u1 = clamp32(u1 + longint'(mdl_adapt_inc));
                end
                mem_v[idx]  = int'(v1);
                mem_u[idx]  = int'(u1);
                mem_ga[idx] = int'(clamp32(round_shift(ga * longint'(mdl_decay_ampa), 16)));
                mem_gg[idx] = int'(clamp32(round_shift(gg * longint'(mdl_decay_gaba), 16)));
            end
            izn_pkg::REQ_BG:   mem_bg[idx] = value;
            izn_pkg::REQ_AMPA: mem_ga[idx] = int'(clamp32(ga + longint'(value)));
            default:           mem_gg[idx] = int'(clamp32(gg + longint'(value)));
        endcase
        res.mem = mem_v[idx];
        return res;
    endfunction

    // Sample the handshakes at each rising edge: apply config, predict requests, check results.
    always @(posedge clk)
    begin
        nrn_result_t exp_res;
        nrn_result_t act_res;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_config(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
            begin
                exp_res = update_neuron(izn_pkg::req_type_t'(s_tuser), s_tdata[9:0],
                                        s_tdata[41:10]);
                // Directed rows with a typed-in result replace the predicted one.
                if (typed_flags.size() > 0 && typed_flags.pop_front())
                    exp_res = typed_results.pop_front();
                pending_results.push_back(exp_res);
            end
            if (m_tvalid && m_tready)
            begin
                act_res.id  = m_tdata[9:0];
                act_res.spk = m_tuser[0];
                act_res.mem = m_tdata[41:10];
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result id=%0d spiked=%0d membrane=%0d",
                             $realtime, act_res.id, act_res.spk, act_res.mem);
                    fail_count++;
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (act_res.id !== exp_res.id)
                    begin
                        $display("%0t: neuron_id expected %0d actual %0d",
                                 $realtime, exp_res.id, act_res.id);
                        fail_count++;
                    end
                    if (act_res.spk !== exp_res.spk)
                    begin
                        $display("%0t: spiked expected %0d actual %0d",
                                 $realtime, exp_res.spk, act_res.spk);
                        fail_count++;
                    end
                    if (act_res.mem !== exp_res.mem)
                    begin
                        $display("%0t: membrane_out expected %0d actual %0d",
                                 $realtime, exp_res.mem, act_res.mem);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Result side: outside burst mode, stall for a random gap before each transaction,
    // and once hold off for a long stretch so the block backs up into its input.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 1'b0;
            end
            stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Offer one request after a random gap and hold it until the block takes it.
    task automatic send_request(input izn_pkg::req_type_t rtype, input logic [9:0] idx,
                                input logic [31:0] value);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = rtype;
        s_tdata  = {6'd0, value, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input izn_pkg::cfg_reg_t idx, input logic [31:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Wait until every expected result has come back, then let the pipe settle.
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Register settings of one phase: defaults, maximum, minimum, random, near default, defaults.
    function automatic logic [31:0] phase_setting(input int phase,
                                                  input izn_pkg::cfg_reg_t idx);
        logic [31:0] dflt;
        bit          unsigned_reg;
        case (idx)
            izn_pkg::CFG_STEP_SCALE: dflt = izn_pkg::STEP_SCALE_INIT;
            izn_pkg::CFG_ADAPT_RATE: dflt = izn_pkg::ADAPT_RATE_INIT;
            izn_pkg::CFG_RESET_V:    dflt = izn_pkg::RESET_VOLTAGE_INIT;
            izn_pkg::CFG_ADAPT_INC:  dflt = izn_pkg::ADAPT_INC_INIT;
            izn_pkg::CFG_THRESHOLD:  dflt = izn_pkg::THRESHOLD_INIT;
            izn_pkg::CFG_GABA_REV:   dflt = izn_pkg::GABA_REV_INIT;
            izn_pkg::CFG_DECAY_AMPA: dflt = izn_pkg::DECAY_AMPA_INIT;
            default:                 dflt = izn_pkg::DECAY_GABA_INIT;
        endcase
        unsigned_reg = (idx == izn_pkg::CFG_STEP_SCALE) || (idx == izn_pkg::CFG_ADAPT_RATE)
                    || (idx == izn_pkg::CFG_DECAY_AMPA) || (idx == izn_pkg::CFG_DECAY_GABA);
        case (phase)
            1: return unsigned_reg ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
            2: return unsigned_reg ? 32'h0000_0000 : 32'h8000_0000;
            3: return $urandom;
            // Near default: rates times 1/2, 1 or 3/2, decays lowered, signed ones shifted.
            4: return unsigned_reg
                      ? (idx >= izn_pkg::CFG_DECAY_AMPA ? dflt - $urandom_range(0, 4000)
                                                        : dflt * $urandom_range(1, 3) / 2)
                      : dflt + $signed($urandom_range(0, 1000000)) - 500000;
            default: return dflt;
        endcase
    endfunction

    function automatic logic [31:0] random_value(input izn_pkg::req_type_t rtype);
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            return $urandom;
        if (rtype == izn_pkg::REQ_BG)
            return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;   // about +-0.5
        if (pick == 1)
            return -$urandom_range(0, 32'h0001_0000);
        return $urandom_range(0, 32'h0010_0000);
    endfunction

    initial
    begin
        izn_pkg::req_type_t rtype;
        logic [9:0]  idx;
        int          pick;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = izn_pkg::REQ_STEP;
        cfg_valid = 1'b0;
        cfg_index = izn_pkg::CFG_STEP_SCALE;
        cfg_data  = '0;
        fail_count   = 0;
        cycle_count  = 0;
        hold_request = 1'b0;
        burst_mode   = 1'b0;
        mdl_step_scale = izn_pkg::STEP_SCALE_INIT;
        mdl_adapt_rate = izn_pkg::ADAPT_RATE_INIT;
        mdl_reset_v    = izn_pkg::RESET_VOLTAGE_INIT;
        mdl_adapt_inc  = izn_pkg::ADAPT_INC_INIT;
        mdl_threshold  = izn_pkg::THRESHOLD_INIT;
        mdl_gaba_rev   = izn_pkg::GABA_REV_INIT;
        mdl_decay_ampa = izn_pkg::DECAY_AMPA_INIT;
        mdl_decay_gaba = izn_pkg::DECAY_GABA_INIT;
        reset_table();

        // Directed rows: after reset every membrane holds the reset voltage, so
        // non-step requests on fresh neurons return it with no spike.
        dir_rows[0]  = '{izn_pkg::REQ_BG,   10'd0,    32'h7FFF_FFFF, 1, 1'b0, V_RST};
        dir_rows[1]  = '{izn_pkg::REQ_BG,   10'd1023, 32'h8000_0000, 1, 1'b0, V_RST};
        dir_rows[2]  = '{izn_pkg::REQ_AMPA, 10'd2,    32'h7FFF_FFFF, 1, 1'b0, V_RST};
        // adding again saturates the conductance
        dir_rows[3]  = '{izn_pkg::REQ_AMPA, 10'd2,    32'h7FFF_FFFF, 1, 1'b0, V_RST};
        dir_rows[4]  = '{izn_pkg::REQ_GABA, 10'd3,    32'h8000_0000, 1, 1'b0, V_RST};
        dir_rows[5]  = '{izn_pkg::REQ_GABA, 10'd3,    32'h8000_0000, 1, 1'b0, V_RST};
        dir_rows[6]  = '{izn_pkg::REQ_STEP, 10'd0,    32'hFFFF_FFFF, 0, 1'b0, 0};
        dir_rows[7]  = '{izn_pkg::REQ_STEP, 10'd1023, 32'h0,         0, 1'b0, 0};
        dir_rows[8]  = '{izn_pkg::REQ_STEP, 10'd2,    32'h0,         0, 1'b0, 0};
        dir_rows[9]  = '{izn_pkg::REQ_STEP, 10'd3,    32'h0,         0, 1'b0, 0};
        dir_rows[10] = '{izn_pkg::REQ_STEP, 10'd4,    32'h0,         0, 1'b0, 0};
        dir_rows[11] = '{izn_pkg::REQ_BG,   10'd4,    32'h0040_0000, 0, 1'b0, 0};
        dir_rows[12] = '{izn_pkg::REQ_STEP, 10'd4,    32'h0,         0, 1'b0, 0};
        dir_rows[13] = '{izn_pkg::REQ_STEP, 10'd4,    32'h0,         0, 1'b0, 0};
        dir_rows[14] = '{izn_pkg::REQ_STEP, 10'd4,    32'h0,         0, 1'b0, 0};
        dir_rows[15] = '{izn_pkg::REQ_STEP, 10'd4,    32'h0,         0, 1'b0, 0};
        dir_rows[16] = '{izn_pkg::REQ_AMPA, 10'd5,    32'h0010_0000, 0, 1'b0, 0};
        dir_rows[17] = '{izn_pkg::REQ_STEP, 10'd5,    32'h0,         0, 1'b0, 0};
        dir_rows[18] = '{izn_pkg::REQ_GABA, 10'd5,    32'h0020_0000, 0, 1'b0, 0};
        dir_rows[19] = '{izn_pkg::REQ_STEP, 10'd5,    32'h0,         0, 1'b0, 0};

        // Hold reset, then release at a falling edge; the clearing pass follows.
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // Idle between phases: write every register.
            for (int r = 0; r < 8; r++)
                write_register(izn_pkg::cfg_reg_t'(r),
                               phase_setting(phase, izn_pkg::cfg_reg_t'(r)));

            if (phase == 0)
            begin
                foreach (dir_rows[k])
                begin
                    typed_flags.push_back(dir_rows[k].typed);
                    if (dir_rows[k].typed)
                        typed_results.push_back(nrn_result_t'{dir_rows[k].idx,
                                                              dir_rows[k].spk,
                                                              dir_rows[k].mem});
                    send_request(dir_rows[k].rtype, dir_rows[k].idx, dir_rows[k].value);
                end
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Alternate stretches of random idling with stretches of none.
                if (n % 50 == 0)
                    burst_mode = ($urandom_range(0, 3) == 0);
                if (phase == 1 && n == 10)
                    hold_request = 1'b1;
                // Pause the sender until the block has delivered everything.
                if (phase == 3 && n == PHASE_ITEMS / 2)
                    drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    rtype = izn_pkg::REQ_STEP;
                else if (pick < 75)
                    rtype = izn_pkg::REQ_BG;
                else if (pick < 87)
                    rtype = izn_pkg::REQ_AMPA;
                else
                    rtype = izn_pkg::REQ_GABA;
                // Keep most traffic on a few neurons so their state evolves to spikes.
                idx = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 7))
                                                  : 10'($urandom_range(0, NRN - 1));
                typed_flags.push_back(1'b0);
                send_request(rtype, idx,
                             rtype == izn_pkg::REQ_STEP ? $urandom : random_value(rtype));
            end
            burst_mode = 1'b0;
            drain_results();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
